/* sv/nlp_pkg.sv */
`default_nettype none
package nlp_pkg;

   localparam int ELEM_LENGTH = 16;   // default sequence capacity
   localparam int QUEUE_AW    = 2;    // queue holds 2**QUEUE_AW words
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } elem_word_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage
`default_nettype wire

/* sv/nlp_front.sv */
`default_nettype none
module nlp_front
   import nlp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [VALUE_W-1:0] req_elem_value,
   input  wire logic                      req_elem_last,
   input  wire q_stat_type                q_stat,
   output logic                           q_push,
   output elem_word_type                  q_word
);

   logic          vld_ff, vld_in;
   elem_word_type word_ff;
   logic          accept;

   // staging word drains into the queue whenever the queue has room
   assign q_push = vld_ff && !q_stat.full;
   assign busy   = vld_ff && q_stat.full;
   assign accept = start && !busy;
   assign q_word = word_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (q_push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.value <= req_elem_value;
         word_ff.last  <= req_elem_last;
      end
   end

endmodule
`default_nettype wire

/* sv/nlp_queue.sv */
`default_nettype none
module nlp_queue
   import nlp_pkg::*;
#(
   parameter int QAW = QUEUE_AW
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire elem_word_type wdata,
   input  wire logic          pop,
   output elem_word_type      rdata,
   output q_stat_type         stat
);

   localparam int DEPTH = 2 ** QAW;

   elem_word_type    slot_ff [DEPTH];
   logic [QAW-1:0]   wptr_ff, wptr_in;
   logic [QAW-1:0]   rptr_ff, rptr_in;
   logic [QAW:0]     fill_ff, fill_in;
   logic             do_push, do_pop;

   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == (QAW+1)'(DEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* sv/nlp_back.sv */
`default_nettype none
module nlp_back
   import nlp_pkg::*;
#(
   parameter int LENGTH = ELEM_LENGTH
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire q_stat_type           q_stat,
   input  wire elem_word_type        q_word,
   output logic                      q_pop,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [INDEX_W-1:0]        rsp_out_index,
   output logic                      rsp_out_last,
   output logic                      rsp_no_successor,
   output logic                      rsp_overflow
);

   localparam int CW = $clog2(LENGTH + 1);
   localparam int AW = $clog2(LENGTH);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_SCAN1 = 2'd1;   // pivot search
   localparam logic [1:0] ST_SCAN2 = 2'd2;   // swap partner search
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic signed [VALUE_W-1:0] mem [LENGTH];

   logic [1:0]                state_ff, state_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      ovf_ff, ovf_in;
   logic                      none_ff, none_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic                      iss_ff, iss_in;
   logic                      rvld_ff, rvld_in;
   logic [AW-1:0]             ridx_ff, ridx_in;
   logic [AW-1:0]             rk_ff, rk_in;
   logic [AW-1:0]             k_ff, k_in;
   logic                      first_ff, first_in;
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] prev_ff, prev_in;
   logic [AW-1:0]             p_ff, p_in;
   logic signed [VALUE_W-1:0] pval_ff, pval_in;
   logic [AW-1:0]             q_ff, q_in;
   logic signed [VALUE_W-1:0] qval_ff, qval_in;

   logic                      o_vld_ff, o_vld_in;
   logic signed [VALUE_W-1:0] o_value_ff, o_value_in;
   logic [INDEX_W-1:0]        o_index_ff, o_index_in;
   logic                      o_last_ff, o_last_in;
   logic                      o_none_ff, o_none_in;
   logic                      o_ovf_ff, o_ovf_in;

   logic                      wr_en;
   logic [AW-1:0]             raddr;
   logic [AW-1:0]             jmir;
   logic [CW:0]               jsum;
   logic [CW-1:0]             n_new;
   logic [AW-1:0]             last_pos;
   logic [AW+INDEX_W-1:0]     rk_wide;

   // suffix after the pivot is emitted mirrored instead of reversed in place
   assign jsum     = {1'b0, cnt_ff} + (CW+1)'(p_ff) - (CW+1)'(k_ff);
   assign jmir     = AW'(jsum);
   assign raddr    = (state_ff == ST_EMIT) ?
                     ((none_ff || k_ff <= p_ff) ? k_ff : jmir) : idx_ff;
   assign last_pos = AW'(cnt_ff - 1'b1);
   assign rk_wide  = {{INDEX_W{1'b0}}, rk_ff};
   assign n_new    = (cnt_ff < CW'(LENGTH)) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      none_in    = none_ff;
      idx_in     = idx_ff;
      iss_in     = iss_ff;
      rvld_in    = 1'b0;
      ridx_in    = raddr;
      rk_in      = k_ff;
      k_in       = k_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      p_in       = p_ff;
      pval_in    = pval_ff;
      q_in       = q_ff;
      qval_in    = qval_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      o_vld_in   = 1'b0;
      o_value_in = rdata_ff;
      o_index_in = rk_wide[INDEX_W-1:0];
      o_last_in  = (rk_ff == last_pos);
      o_none_in  = none_ff;
      o_ovf_in   = ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (!q_stat.empty) begin
               q_pop  = 1'b1;
               cnt_in = n_new;
               if (cnt_ff < CW'(LENGTH)) begin
                  wr_en = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (q_word.last) begin
                  iss_in = 1'b1;
                  if (n_new < CW'(2)) begin
                     none_in  = 1'b1;
                     k_in     = '0;
                     state_in = ST_EMIT;
                  end else begin
                     idx_in   = AW'(n_new - 1'b1);
                     first_in = 1'b1;
                     state_in = ST_SCAN1;
                  end
               end
            end
         end
         ST_SCAN1, ST_SCAN2: begin
            rvld_in = iss_ff;
            if (iss_ff) begin
               if (idx_ff == '0) begin
                  iss_in = 1'b0;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            if (rvld_ff && state_ff == ST_SCAN1) begin
               if (first_ff) begin
                  prev_in  = rdata_ff;
                  first_in = 1'b0;
               end else if (rdata_ff < prev_ff) begin
                  p_in     = ridx_ff;
                  pval_in  = rdata_ff;
                  idx_in   = last_pos;
                  iss_in   = 1'b1;
                  rvld_in  = 1'b0;
                  state_in = ST_SCAN2;
               end else begin
                  prev_in = rdata_ff;
                  if (ridx_ff == '0) begin
                     none_in  = 1'b1;
                     k_in     = '0;
                     iss_in   = 1'b1;
                     rvld_in  = 1'b0;
                     state_in = ST_EMIT;
                  end
               end
            end else if (rvld_ff && pval_ff < rdata_ff) begin
               // suffix is non-increasing, so the first hit from the right is it
               q_in     = ridx_ff;
               qval_in  = rdata_ff;
               k_in     = '0;
               iss_in   = 1'b1;
               rvld_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rvld_in = iss_ff;
            if (iss_ff) begin
               if (k_ff == last_pos) begin
                  iss_in = 1'b0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
            if (rvld_ff) begin
               o_vld_in = 1'b1;
               if (!none_ff && ridx_ff == p_ff) begin
                  o_value_in = qval_ff;
               end else if (!none_ff && ridx_ff == q_ff) begin
                  o_value_in = pval_ff;
               end
               if (rk_ff == last_pos) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  none_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         none_ff  <= 1'b0;
         iss_ff   <= 1'b0;
         rvld_ff  <= 1'b0;
         first_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         none_ff  <= none_in;
         iss_ff   <= iss_in;
         rvld_ff  <= rvld_in;
         first_ff <= first_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      ridx_ff    <= ridx_in;
      rk_ff      <= rk_in;
      k_ff       <= k_in;
      prev_ff    <= prev_in;
      p_ff       <= p_in;
      pval_ff    <= pval_in;
      q_ff       <= q_in;
      qval_ff    <= qval_in;
      o_value_ff <= o_value_in;
      o_index_ff <= o_index_in;
      o_last_ff  <= o_last_in;
      o_none_ff  <= o_none_in;
      o_ovf_ff   <= o_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= q_word.value;
      end
      rdata_ff <= mem[raddr];
   end

   assign rsp_strobe       = o_vld_ff;
   assign rsp_out_value    = o_value_ff;
   assign rsp_out_index    = o_index_ff;
   assign rsp_out_last     = o_last_ff;
   assign rsp_no_successor = o_none_ff;
   assign rsp_overflow     = o_ovf_ff;

endmodule
`default_nettype wire

/* sv/next_lexicographic_permutation.sv */
// Next lexicographic permutation of a stored sequence.
// Input: one element word per start pulse (start high, busy low at the edge);
// req_elem_last closes the sequence. Up to LENGTH elements are kept, later
// ones are dropped and reported through rsp_overflow.
// Output: after the closing word, the successor sequence comes out as one
// word per cycle on rsp_strobe, index 0 first, rsp_out_last on the final one.
// rsp_no_successor is set on every word when the input was the last
// permutation, which is then returned unchanged.
// Throughput: the input side takes one word per cycle while busy is low, into
// a four-word queue; the sequence engine drains it at one word per cycle, but
// only while loading a sequence. After the closing word leaves the queue, a
// pivot scan and, if a pivot is found, a partner scan run from the right, then
// the output words pass the read and output registers. All scans go through
// the single read port of the element memory. busy is high only while the
// queue and staging word are full.
// The receiver cannot stall: each result word is valid for one cycle only.
// Reset clears the queue, the element count and all strobes; the element
// memory needs no clearing.
`default_nettype none
module next_lexicographic_permutation
   import nlp_pkg::*;
#(
   parameter int LENGTH = ELEM_LENGTH
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [VALUE_W-1:0] req_elem_value,
   input  wire logic                      req_elem_last,
   output logic                           rsp_strobe,
   output logic signed [VALUE_W-1:0]      rsp_out_value,
   output logic [INDEX_W-1:0]             rsp_out_index,
   output logic                           rsp_out_last,
   output logic                           rsp_no_successor,
   output logic                           rsp_overflow
);

   q_stat_type    q_stat;
   logic          q_push;
   logic          q_pop;
   elem_word_type q_wdata;
   elem_word_type q_rdata;

   nlp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_elem_value (req_elem_value),
      .req_elem_last  (req_elem_last),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_word         (q_wdata)
   );

   nlp_queue #(
      .QAW (QUEUE_AW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   nlp_back #(
      .LENGTH (LENGTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .q_word           (q_rdata),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_index    (rsp_out_index),
      .rsp_out_last     (rsp_out_last),
      .rsp_no_successor (rsp_no_successor),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
`default_nettype wire

/* sv/nlp_checker.sv */
`default_nettype none
module nlp_checker
   import nlp_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic signed [VALUE_W-1:0] req_elem_value,
   input wire logic                      req_elem_last,
   input wire logic                      rsp_strobe,
   input wire logic signed [VALUE_W-1:0] rsp_out_value,
   input wire logic [INDEX_W-1:0]        rsp_out_index,
   input wire logic                      rsp_out_last,
   input wire logic                      rsp_no_successor,
   input wire logic                      rsp_overflow
);

   // a sequence starts at index 0
   a_first_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(rsp_strobe) |-> rsp_out_index == '0)
      else $error("sequence does not start at index 0");

   // words of one sequence come back to back with rising index
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=>
         rsp_strobe && rsp_out_index == $past(rsp_out_index) + 1'b1)
      else $error("gap or index skip inside a sequence");

   // sequence flags hold across a sequence
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=>
         rsp_no_successor == $past(rsp_no_successor) &&
         rsp_overflow == $past(rsp_overflow))
      else $error("sequence flags changed mid-sequence");

   // the strobe is low right after the last word of a sequence
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !rsp_strobe)
      else $error("word right after the last word");

   // no output straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe after reset");

endmodule

bind next_lexicographic_permutation nlp_checker u_nlp_checker (.*);
`default_nettype wire
